/* hdl/gbf_pkg.sv */
// State type of the graph bridge finder.
package gbf_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_B,
		ST_LOAD_A,
		ST_ROOT,
		ST_FETCH,
		ST_EXAM,
		ST_LOW,
		ST_VISIT,
		ST_POP,
		ST_RET,
		ST_EMIT,
		ST_TERM,
		ST_CLEAR
	} gbf_state_t;

endpackage

/* hdl/graph_bridge_finder.sv */
// Bridge finder: adjacency list loader and iterative depth-first search sequencer.
// An edge item is accepted, then prepended once per endpoint; a dropped edge is only accepted.
// An end item roots the search; each adjacency entry is fetched and examined, then the low value is
// updated or a tree descent made; a returned node passes POP, RET and EMIT, the root TERM and CLEAR.
// A bridge or terminator step waits while the previous result is held by out_stall.
// Reset (arst_n low) empties every list, clears the visited marks and sets node_count to MAX_NODES.
module graph_bridge_finder #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	input  logic       end_of_graph,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] bridge_near,
	output logic [5:0] bridge_far,
	output logic       final_res
);
	import gbf_pkg::*;

	localparam int ENTRIES = 2 * MAX_EDGES;
	localparam int EW = $clog2(ENTRIES + 1);
	localparam int AW = $clog2(ENTRIES);
	localparam int NW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);
	localparam logic [EW-1:0] NIL = EW'(ENTRIES);

	gbf_state_t state_q, state_d;

	logic [6:0]    node_count_q;
	logic [EW-1:0] entry_count_q;
	logic [SW-1:0] top_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] head_ok_q;
	logic [5:0]    a_q, b_q;
	logic [EW-1:0] hd_q;

	// Adjacency store and stack frames.
	logic [EW-1:0] head_mem [MAX_NODES];
	logic [5:0]    nb_mem   [ENTRIES];
	logic [EW-1:0] link_mem [ENTRIES];
	logic [5:0]    depth_mem [MAX_NODES];
	logic [5:0]    sn_mem [MAX_NODES];
	logic [5:0]    sp_mem [MAX_NODES];
	logic [EW-1:0] sc_mem [MAX_NODES];
	logic [5:0]    sl_mem [MAX_NODES];

	// Current frame held in registers.
	logic [5:0]    cur_node_q, cur_par_q, cur_low_q, cur_depth_q;
	logic [EW-1:0] cur_cur_q;
	logic [5:0]    v_q, v_depth_q;
	logic [EW-1:0] v_next_q;
	logic [5:0]    ret_low_q, child_q;

	logic [5:0]    out_near_q, out_far_q;
	logic          out_fin_q, out_valid_q;
	logic [SW-1:0] n_out_q;

	logic [6:0] sat_cfg;
	logic       accept, edge_ok;

	assign sat_cfg = (cfg_wdata == 7'd0) ? 7'd1 :
		((cfg_wdata > 7'(MAX_NODES)) ? 7'(MAX_NODES) : cfg_wdata);
	assign accept = in_valid && !in_stall;
	assign edge_ok = (7'(node_a) < node_count_q) && (7'(node_b) < node_count_q) &&
		(32'(entry_count_q) + 32'd2 <= 32'(ENTRIES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (end_of_graph) state_d = ST_ROOT;
					else if (edge_ok) state_d = ST_LOAD_B;
				end
			end
			ST_LOAD_B: state_d = ST_LOAD_A;
			ST_LOAD_A: state_d = ST_IDLE;
			ST_ROOT:   state_d = ST_FETCH;
			ST_FETCH:  state_d = (cur_cur_q < NIL) ? ST_EXAM : ST_POP;
			ST_EXAM: begin
				if (v_q == cur_par_q) state_d = ST_FETCH;
				else if (visited_q[v_q[NW-1:0]]) state_d = ST_LOW;
				else if (32'(top_q) < MAX_NODES) state_d = ST_VISIT;
				else state_d = ST_FETCH;
			end
			ST_LOW:    state_d = ST_FETCH;
			ST_VISIT:  state_d = ST_FETCH;
			ST_POP:    state_d = (top_q == SW'(1)) ? ST_TERM : ST_RET;
			ST_RET:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) state_d = ST_FETCH;
			end
			ST_TERM: begin
				if (!out_valid_q || !out_stall) state_d = ST_CLEAR;
			end
			ST_CLEAR:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	assign out_valid = out_valid_q;
	assign bridge_near = out_near_q;
	assign bridge_far = out_far_q;
	assign final_res = out_fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_count_q <= 7'(MAX_NODES);
			entry_count_q <= '0;
			top_q <= '0;
			visited_q <= '0;
			head_ok_q <= '0;
			out_valid_q <= 1'b0;
			n_out_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) node_count_q <= sat_cfg;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD_B: begin
					entry_count_q <= entry_count_q + EW'(1);
					head_ok_q[b_q[NW-1:0]] <= 1'b1;
				end
				ST_LOAD_A: begin
					entry_count_q <= entry_count_q + EW'(1);
					head_ok_q[a_q[NW-1:0]] <= 1'b1;
				end
				ST_ROOT: begin
					visited_q[0] <= 1'b1;
					top_q <= SW'(1);
					n_out_q <= '0;
				end
				ST_VISIT: begin
					visited_q[v_q[NW-1:0]] <= 1'b1;
					top_q <= top_q + SW'(1);
				end
				ST_POP: top_q <= top_q - SW'(1);
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						if (ret_low_q > cur_depth_q && 32'(n_out_q) < MAX_NODES - 1) begin
							out_valid_q <= 1'b1;
							n_out_q <= n_out_q + SW'(1);
						end
					end
				end
				ST_TERM: begin
					if (!out_valid_q || !out_stall) out_valid_q <= 1'b1;
				end
				ST_CLEAR: begin
					visited_q <= '0;
					head_ok_q <= '0;
					entry_count_q <= '0;
					top_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload and memories.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			a_q <= node_a;
			b_q <= node_b;
			hd_q <= head_mem[end_of_graph ? NW'(0) : node_b[NW-1:0]];
		end
		case (state_q)
			ST_LOAD_B: begin
				nb_mem[entry_count_q[AW-1:0]] <= a_q;
				link_mem[entry_count_q[AW-1:0]] <= head_ok_q[b_q[NW-1:0]] ? hd_q : NIL;
				head_mem[b_q[NW-1:0]] <= entry_count_q;
				// A self loop must see the entry that was just prepended.
				hd_q <= (a_q == b_q) ? entry_count_q : head_mem[a_q[NW-1:0]];
			end
			ST_LOAD_A: begin
				nb_mem[entry_count_q[AW-1:0]] <= b_q;
				link_mem[entry_count_q[AW-1:0]] <= head_ok_q[a_q[NW-1:0]] ? hd_q : NIL;
				head_mem[a_q[NW-1:0]] <= entry_count_q;
			end
			ST_ROOT: begin
				depth_mem[0] <= '0;
				cur_node_q <= '0;
				cur_par_q <= '0;
				cur_low_q <= '0;
				cur_depth_q <= '0;
				cur_cur_q <= head_ok_q[0] ? hd_q : NIL;
			end
			ST_FETCH: begin
				if (cur_cur_q < NIL) begin
					v_q <= nb_mem[cur_cur_q[AW-1:0]];
					v_next_q <= link_mem[cur_cur_q[AW-1:0]];
				end
			end
			ST_EXAM: begin
				cur_cur_q <= v_next_q;
				v_depth_q <= depth_mem[v_q[NW-1:0]];
				hd_q <= head_mem[v_q[NW-1:0]];
			end
			ST_LOW: begin
				if (v_depth_q < cur_low_q) cur_low_q <= v_depth_q;
			end
			ST_VISIT: begin
				// Park the current frame, then make the new node current.
				sn_mem[top_q[NW-1:0] - NW'(1)] <= cur_node_q;
				sp_mem[top_q[NW-1:0] - NW'(1)] <= cur_par_q;
				sc_mem[top_q[NW-1:0] - NW'(1)] <= cur_cur_q;
				sl_mem[top_q[NW-1:0] - NW'(1)] <= cur_low_q;
				depth_mem[v_q[NW-1:0]] <= 6'(top_q);
				cur_node_q <= v_q;
				cur_par_q <= cur_node_q;
				cur_low_q <= 6'(top_q);
				cur_depth_q <= 6'(top_q);
				cur_cur_q <= head_ok_q[v_q[NW-1:0]] ? hd_q : NIL;
			end
			ST_POP: begin
				ret_low_q <= cur_low_q;
				child_q <= cur_node_q;
			end
			ST_RET: begin
				// A frame's depth equals its stack position.
				cur_node_q <= sn_mem[top_q[NW-1:0] - NW'(1)];
				cur_par_q <= sp_mem[top_q[NW-1:0] - NW'(1)];
				cur_cur_q <= sc_mem[top_q[NW-1:0] - NW'(1)];
				cur_low_q <= sl_mem[top_q[NW-1:0] - NW'(1)];
				cur_depth_q <= 6'(top_q - SW'(1));
			end
			ST_EMIT: begin
				if (ret_low_q < cur_low_q) cur_low_q <= ret_low_q;
				if (!out_valid_q || !out_stall) begin
					out_near_q <= cur_node_q;
					out_far_q <= child_q;
					out_fin_q <= 1'b0;
				end
			end
			ST_TERM: begin
				if (!out_valid_q || !out_stall) begin
					out_near_q <= '0;
					out_far_q <= '0;
					out_fin_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("item accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(bridge_far)))
		else $error("stalled result changed");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(entry_count_q) <= ENTRIES)
		else $error("entry count over capacity");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (visited_q == '0 && top_q == '0))
		else $error("store not cleared after terminator");

endmodule

/* test/graph_bridge_checker.sv */
// Checker for the graph bridge finder: watches both channels, predicts bridges and compares.
module graph_bridge_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	input  logic       end_of_graph,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [5:0] bridge_near,
	input  logic [5:0] bridge_far,
	input  logic       final_res,
	output int         fail_count,
	output int         pending_count
);
	localparam int NODES = 64;
	localparam int ENTRIES = 512;
	localparam int NIL = ENTRIES;

	typedef struct packed {
		logic [5:0] near;
		logic [5:0] far;
		logic       term;
	} bridge_t;

	bridge_t     bridge_q[$];
	int unsigned nodes_in_use;
	int unsigned head[NODES];
	int unsigned nbr[ENTRIES];
	int unsigned link[ENTRIES];
	int unsigned used;

	function automatic void empty_graph();
		for (int k = 0; k < NODES; k++)
			head[k] = NIL;
		used = 0;
	endfunction

	// Iterative search with the low value taken from depths; bridges go out in post-order.
	function automatic void find_bridges();
		bit          seen[NODES];
		int unsigned dep[NODES];
		int unsigned s_node[NODES], s_par[NODES], s_cur[NODES], s_low[NODES];
		int unsigned top, f, cur, v, ret, child, p, found;
		bridge_t     b;
		found = 0;
		for (int k = 0; k < NODES; k++)
			seen[k] = 0;
		seen[0] = 1; dep[0] = 0;
		s_node[0] = 0; s_par[0] = 0; s_cur[0] = head[0]; s_low[0] = 0;
		top = 1;
		while (top > 0) begin
			f = top - 1;
			cur = s_cur[f];
			if (cur < ENTRIES) begin
				v = nbr[cur] % NODES;
				s_cur[f] = link[cur];
				if (v != s_par[f]) begin
					if (!seen[v]) begin
						if (top < NODES) begin
							seen[v] = 1; dep[v] = top;
							s_node[top] = v; s_par[top] = s_node[f];
							s_cur[top] = head[v]; s_low[top] = top;
							top++;
						end
					end else if (dep[v] < s_low[f]) begin
						s_low[f] = dep[v];
					end
				end
			end else begin
				ret = s_low[f];
				child = s_node[f];
				top--;
				if (top > 0) begin
					p = top - 1;
					if (ret < s_low[p])
						s_low[p] = ret;
					if (ret > dep[s_node[p]] && found < NODES - 1) begin
						b.near = s_node[p][5:0];
						b.far = child[5:0];
						b.term = 1'b0;
						bridge_q.push_back(b);
						found++;
					end
				end
			end
		end
		b = '0;
		b.term = 1'b1;
		bridge_q.push_back(b);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bridge_t exp_b;
		int unsigned v;
		if (!arst_n) begin
			nodes_in_use = NODES;
			empty_graph();
			bridge_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (bridge_q.size() == 0) begin
					$display("%0t: unexpected result near=%0d far=%0d final=%0b",
						$time, bridge_near, bridge_far, final_res);
					fail_count++;
				end else begin
					exp_b = bridge_q.pop_front();
					if (bridge_near !== exp_b.near || bridge_far !== exp_b.far ||
							final_res !== exp_b.term) begin
						$display("%0t: expected near=%0d far=%0d final=%0b, got %0d %0d %0b",
							$time, exp_b.near, exp_b.far, exp_b.term,
							bridge_near, bridge_far, final_res);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (end_of_graph) begin
					find_bridges();
					empty_graph();
				end else if (node_a < nodes_in_use && node_b < nodes_in_use &&
						used + 2 <= ENTRIES) begin
					nbr[used] = node_a; link[used] = head[node_b]; head[node_b] = used; used++;
					nbr[used] = node_b; link[used] = head[node_a]; head[node_a] = used; used++;
				end
			end
			if (cfg_we) begin
				v = cfg_wdata;
				nodes_in_use = (v < 1) ? 1 : (v > NODES) ? NODES : v;
			end
			pending_count = bridge_q.size();
		end
	end
endmodule

/* test/graph_bridge_finder_tb.sv */
// Testbench top for the graph bridge finder: stimulus, idling and the verdict.
module graph_bridge_finder_tb;
	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [5:0] node_a;
	logic [5:0] node_b;
	logic       end_of_graph;
	logic       out_valid;
	logic       out_stall;
	logic [5:0] bridge_near;
	logic [5:0] bridge_far;
	logic       final_res;
	int         fail_count;
	int         pending_count;
	int         hold_cycles;

	graph_bridge_finder dut (.*);
	graph_bridge_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		else if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// Offers one item and returns at the edge that accepts it; valid stays up for a
	// following item with no gap.
	task automatic send_item(input logic [5:0] a, input logic [5:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		node_a <= a;
		node_b <= b;
		end_of_graph <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_edge(input int unsigned a, input int unsigned b);
		send_item(a[5:0], b[5:0], 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		// Leave the block idle for a while before the next item.
		repeat (150) @(posedge clk);
	endtask

	// Waits until the block is idle, then writes the node count.
	task automatic set_nodes(input logic [6:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (in_stall);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// A tree-like random graph plus a few extra edges, ended by a search item.
	task automatic random_graph(input int unsigned n, input int edges);
		int unsigned a, b;
		for (int k = 0; k < edges; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				a = $urandom_range(0, 63);
				b = $urandom_range(0, 63);
			end else begin
				b = $urandom_range(1, (n > 1) ? n - 1 : 0);
				a = (k < n - 1 && $urandom_range(0, 3) != 0) ? $urandom_range(0, b - 1)
					: $urandom_range(0, n - 1);
				if ($urandom_range(0, 1)) begin
					a ^= b; b ^= a; a ^= b;
				end
			end
			send_edge(a, b);
		end
		send_item(6'($urandom), 6'($urandom), 1'b1);
	endtask

	initial begin
		out_stall = 1'b0;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				out_stall <= 1'b1;
				hold_cycles = $urandom_range(5, 30);
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		node_a = '0;
		node_b = '0;
		end_of_graph = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Chain with a cycle, a self loop, parallel edges and extreme ids.
		send_edge(0, 1); send_edge(1, 2); send_edge(2, 3); send_edge(3, 1);
		send_edge(3, 3); send_edge(2, 4); send_edge(4, 2); send_edge(0, 63);
		send_edge(63, 62); send_edge(0, 0); send_edge(5, 6);
		send_item(6'h3f, 6'h3f, 1'b1);
		wait_drained();
		// Empty graph, then out-of-range edges after a smaller node count.
		send_item(6'd0, 6'd0, 1'b1);
		wait_drained();
		set_nodes(7'd8);
		send_edge(0, 8); send_edge(9, 1); send_edge(0, 7); send_edge(7, 6);
		set_nodes(7'd3);
		send_edge(0, 1);
		send_item(6'd0, 6'd0, 1'b1);
		wait_drained();
		set_nodes(7'd0);
		send_edge(0, 0); send_edge(0, 1);
		send_item(6'd0, 6'd0, 1'b1);
		wait_drained();
		set_nodes(7'd127);
		// Fill the store past capacity with a long path.
		for (int k = 0; k < 258; k++)
			send_edge(k % 63, k % 63 + 1);
		send_item(6'd0, 6'd0, 1'b1);
		wait_drained();

		// Receiver holds off while graphs keep arriving and results pile up.
		hold_cycles = 400;
		random_graph(12, 10);
		random_graph(10, 9);
		random_graph(10, 9);
		wait_drained();

		for (int g = 0; g < 4; g++) begin
			int unsigned n;
			n = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(2, 16);
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				set_nodes(7'(n));
			end
			random_graph(n, $urandom_range(1, 12));
		end
		wait_drained();
		if (fail_count == 0 && pending_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end
endmodule

/* sim.f */
hdl/gbf_pkg.sv
hdl/graph_bridge_finder.sv
test/graph_bridge_checker.sv
test/graph_bridge_finder_tb.sv
